>>> rtl/sha256_byte_stream_hasher_unit_macros.svh
// assertion macros for the sha-256 byte stream hasher
`ifndef SHA256_BYTE_STREAM_HASHER_UNIT_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_UNIT_MACROS_SVH

// assert that an antecedent implies a consequent in the same cycle
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// assert that an antecedent implies a consequent in the next cycle
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sha_pkg.sv
// package with types and constants for the sha-256 byte stream hasher
package sha_pkg;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out;

    localparam logic MODE_ABSORB = 1'b0;
    localparam logic MODE_FINISH = 1'b1;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int unsigned LEN_POS = 56;

    localparam logic [31:0] INIT_VALUE [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] round_const(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

>>> rtl/sha256_byte_stream_hasher_unit.sv
// SHA-256 byte stream hasher: each absorb transaction writes one byte into a
// 16-word block memory; every 64th byte starts a compression. The compression
// loads each of the first 16 message words through a read state and a round
// state (the block memory is read one word per cycle through a registered read
// port), and for rounds 16 to 63 spends one address state and then four phases
// in which the four schedule taps arrive one at a time from the same memory; it
// then adds into the chaining value. No byte is taken during a compression. A
// finish transaction writes the padding (one word per cycle), runs one or two
// compressions and then offers the eight digest words, one per cycle while the
// output is ready.
`include "sha256_byte_stream_hasher_unit_macros.svh"

module sha256_byte_stream_hasher_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  sha_pkg::t_in     i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output sha_pkg::t_out    o_data
);

    // state codes
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_RND  = 3'd3;
    localparam logic [2:0] ST_ADD  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]  r_state;
    logic [5:0]  r_fill;
    logic [60:0] r_count;
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_word;       // partially assembled block word
    logic [5:0]  r_round;
    logic [1:0]  r_phase;      // schedule tap read phase
    logic [31:0] r_acc;        // schedule accumulator
    logic        r_fin;        // finishing a message
    logic        r_second;     // last padding block pending
    logic [3:0]  r_pad_idx;    // padding word index
    logic [3:0]  r_pad_end;    // last word to write for this padding block
    logic [2:0]  r_out_idx;

    // memory ports
    logic        mem_we;
    logic [3:0]  mem_waddr;
    logic [31:0] mem_wdata;
    logic [3:0]  mem_raddr;
    logic [31:0] mem_rdata;

    sha_ram #(.WIDTH(32), .DEPTH(16)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    logic        in_acc;
    logic [31:0] byte_word;
    logic [63:0] bits;
    logic [31:0] pad_word;
    logic [31:0] w_cur;
    logic [31:0] t1, t2, big0, big1, ch, maj, s0, s1;
    logic [3:0]  rd_addr_sched;

    assign o_ready = (r_state == ST_IDLE);
    assign in_acc  = i_valid && o_ready;
    assign bits    = {r_count, 3'b000};

    // current block word with the new byte merged in
    always_comb begin
        byte_word = r_word;
        case (r_fill[1:0])
            2'd0: byte_word = {i_data.data_byte, 24'h0};
            2'd1: byte_word[23:16] = i_data.data_byte;
            2'd2: byte_word[15:8] = i_data.data_byte;
            2'd3: byte_word[7:0] = i_data.data_byte;
            default: byte_word = r_word;
        endcase
    end

    // padding word for the current pad index
    always_comb begin
        pad_word = 32'h0;
        if (r_pad_idx == 4'd14 && !r_second) begin
            pad_word = bits[63:32];
        end else if (r_pad_idx == 4'd15 && !r_second) begin
            pad_word = bits[31:0];
        end
    end

    // schedule tap read address, one tap ahead of the data arriving:
    // t-15 while t-16 arrives, t-7 while t-15 arrives, t-2 while t-7 arrives
    always_comb begin
        case (r_phase)
            2'd0: rd_addr_sched = r_round[3:0] + 4'd1;
            2'd1: rd_addr_sched = r_round[3:0] + 4'd9;
            2'd2: rd_addr_sched = r_round[3:0] + 4'd14;
            default: rd_addr_sched = r_round[3:0];
        endcase
    end

    assign s0 = sha_pkg::rotr(mem_rdata, 7) ^ sha_pkg::rotr(mem_rdata, 18)
              ^ (mem_rdata >> 3);
    assign s1 = sha_pkg::rotr(mem_rdata, 17) ^ sha_pkg::rotr(mem_rdata, 19)
              ^ (mem_rdata >> 10);
    assign w_cur = (r_round < 6'd16) ? mem_rdata : (r_acc + s1);

    // round function
    assign big1 = sha_pkg::rotr(r_v[4], 6) ^ sha_pkg::rotr(r_v[4], 11)
                ^ sha_pkg::rotr(r_v[4], 25);
    assign ch   = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign big0 = sha_pkg::rotr(r_v[0], 2) ^ sha_pkg::rotr(r_v[0], 13)
                ^ sha_pkg::rotr(r_v[0], 22);
    assign maj  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1   = r_v[7] + big1 + ch + sha_pkg::round_const(r_round) + w_cur;
    assign t2   = big0 + maj;

    // memory access control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_fill[5:2];
        mem_wdata = byte_word;
        mem_raddr = r_round[3:0];
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_fill[5:2];
                    mem_wdata = (i_data.mode == sha_pkg::MODE_FINISH)
                              ? (byte_word & ~(32'hffffffff >> {r_fill[1:0], 3'b000}))
                                | ({sha_pkg::PAD_BYTE, 24'h0} >> {r_fill[1:0], 3'b000})
                              : byte_word;
                end
            end
            ST_PAD: begin
                mem_we    = 1'b1;
                mem_waddr = r_pad_idx;
                mem_wdata = pad_word;
            end
            ST_RD: begin
                // block word t, or schedule tap t-16 which shares its slot
                mem_raddr = r_round[3:0];
            end
            ST_RND: begin
                mem_raddr = rd_addr_sched;
                if (r_round >= 6'd16 && r_phase == 2'd3) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_round[3:0];
                    mem_wdata = w_cur;
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // control and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_fill    <= 6'd0;
            r_count   <= 61'd0;
            r_fin     <= 1'b0;
            r_second  <= 1'b0;
            r_out_idx <= 3'd0;
            r_phase   <= 2'd0;
            r_round   <= 6'd0;
            r_pad_idx <= 4'd0;
            r_pad_end <= 4'd0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= sha_pkg::INIT_VALUE[i];
            end
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_word <= byte_word;
                        if (i_data.mode == sha_pkg::MODE_ABSORB) begin
                            r_count <= r_count + 61'd1;
                            r_fill  <= r_fill + 6'd1;
                            if (r_fill == 6'd63) begin
                                r_state <= ST_RD;
                                r_round <= 6'd0;
                                r_phase <= 2'd0;
                                r_fin   <= 1'b0;
                                for (int i = 0; i < 8; i++) begin
                                    r_v[i] <= r_h[i];
                                end
                            end
                        end else begin
                            r_fin     <= 1'b1;
                            r_state   <= ST_PAD;
                            r_pad_idx <= r_fill[5:2] + 4'd1;
                            if (r_fill >= 6'd56) begin
                                r_second  <= 1'b1;
                                r_pad_end <= 4'd15;
                            end else begin
                                r_second  <= 1'b0;
                                r_pad_end <= 4'd15;
                            end
                            // last block word: no zero words to write
                            if (r_fill[5:2] == 4'd15) begin
                                r_state <= ST_RD;
                                r_round <= 6'd0;
                                r_phase <= 2'd0;
                                for (int i = 0; i < 8; i++) begin
                                    r_v[i] <= r_h[i];
                                end
                            end
                        end
                    end
                end
                ST_PAD: begin
                    r_pad_idx <= r_pad_idx + 4'd1;
                    if (r_pad_idx == r_pad_end) begin
                        r_state <= ST_RD;
                        r_round <= 6'd0;
                        r_phase <= 2'd0;
                        for (int i = 0; i < 8; i++) begin
                            r_v[i] <= r_h[i];
                        end
                    end
                end
                ST_RD: begin
                    r_state <= ST_RND;
                end
                ST_RND: begin
                    if (r_round >= 6'd16 && r_phase != 2'd3) begin
                        // gather schedule taps
                        case (r_phase)
                            2'd0: r_acc <= mem_rdata;
                            2'd1: r_acc <= r_acc + s0;
                            2'd2: r_acc <= r_acc + mem_rdata;
                            default: r_acc <= r_acc;
                        endcase
                        r_phase <= r_phase + 2'd1;
                    end else begin
                        r_v[7] <= r_v[6];
                        r_v[6] <= r_v[5];
                        r_v[5] <= r_v[4];
                        r_v[4] <= r_v[3] + t1;
                        r_v[3] <= r_v[2];
                        r_v[2] <= r_v[1];
                        r_v[1] <= r_v[0];
                        r_v[0] <= t1 + t2;
                        r_phase <= 2'd0;
                        r_round <= r_round + 6'd1;
                        if (r_round == 6'd63) begin
                            r_state <= ST_ADD;
                        end else begin
                            r_state <= ST_RD;
                        end
                    end
                end
                ST_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                    end
                    r_fill <= 6'd0;
                    if (!r_fin) begin
                        r_state <= ST_IDLE;
                    end else if (r_second) begin
                        r_second  <= 1'b0;
                        r_pad_idx <= 4'd0;
                        r_pad_end <= 4'd15;
                        r_state   <= ST_PAD;
                    end else begin
                        r_out_idx <= 3'd0;
                        r_state   <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (i_ready) begin
                        r_out_idx <= r_out_idx + 3'd1;
                        if (r_out_idx == 3'd7) begin
                            r_state <= ST_IDLE;
                            r_fin   <= 1'b0;
                            r_count <= 61'd0;
                            r_fill  <= 6'd0;
                            for (int i = 0; i < 8; i++) begin
                                r_h[i] <= sha_pkg::INIT_VALUE[i];
                            end
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // result transaction
    assign o_valid            = (r_state == ST_OUT);
    assign o_data.digest_word = r_h[r_out_idx];
    assign o_data.word_index  = r_out_idx;
    assign o_data.last_word   = (r_out_idx == 3'd7);

    // checks
    `SHA_ASSERT_IMP(a_no_in_busy, i_clk, i_rst_n, o_valid, !o_ready, "input taken while emitting")
    `SHA_ASSERT_NEXT(a_out_end, i_clk, i_rst_n, o_valid && i_ready && o_data.last_word, r_state == ST_IDLE && r_count == 61'd0, "no return to idle after last word")
    `SHA_ASSERT_IMP(a_phase_early, i_clk, i_rst_n, r_state == ST_RND && r_round < 6'd16, r_phase == 2'd0, "tap phase in early rounds")

endmodule

>>> rtl/sha_ram.sv
// generic single-port write, single-port read ram with registered read
module sha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
